FILE: design/ftc_pkg.sv
// Shared types, constants and divisor tables for the frame-to-timecode block.
// Used by frame_to_timecode_unit, ftc_div, ftc_checker and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ftc_pkg;

    localparam int FRAME_NUMBER_WIDTH = 28;

    // divider datapath widths: dividend, divisor, reciprocal, product
    localparam int DIV_XW = FRAME_NUMBER_WIDTH + 3;
    localparam int DIV_DW = 19;
    localparam int DIV_MW = DIV_XW - 4;
    localparam int DIV_PW = DIV_XW + DIV_MW;
    localparam longint unsigned DIV_ONE = 64'd1 << DIV_XW;

    localparam int HOURS_W = 12;
    localparam int FIELD_W = 6;
    localparam int R2_W    = 17;

    // register index (paddr bit 2)
    localparam logic REG_DFE  = 1'b0;
    localparam logic REG_RATE = 1'b1;

    localparam logic [3:0] RC_23976 = 4'd1;
    localparam logic [3:0] RC_24    = 4'd2;
    localparam logic [3:0] RC_25    = 4'd3;
    localparam logic [3:0] RC_2997  = 4'd4;
    localparam logic [3:0] RC_30    = 4'd5;
    localparam logic [3:0] RC_50    = 4'd6;
    localparam logic [3:0] RC_5994  = 4'd7;
    localparam logic [3:0] RC_60    = 4'd8;

    typedef enum logic [2:0] {
        FPS_24,
        FPS_25,
        FPS_30,
        FPS_50,
        FPS_60
    } t_fps;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_div_en;

    // drop-frame arithmetic in 1/120 s units
    localparam logic [DIV_DW-1:0] DIV_DROP_HOUR   = DIV_DW'(431568);
    localparam logic [DIV_DW-1:0] DIV_DROP_TENMIN = DIV_DW'(71928);
    localparam logic [DIV_DW-1:0] DIV_DROP_MIN    = DIV_DW'(7192);
    localparam logic [DIV_DW-1:0] DIV_UNIT_SEC    = DIV_DW'(120);
    localparam logic [DIV_DW-1:0] DROP_UNITS      = DIV_DW'(8);

    localparam logic [DIV_MW-1:0] RCP_DROP_HOUR   = DIV_MW'(DIV_ONE / 64'd431568);
    localparam logic [DIV_MW-1:0] RCP_DROP_TENMIN = DIV_MW'(DIV_ONE / 64'd71928);
    localparam logic [DIV_MW-1:0] RCP_DROP_MIN    = DIV_MW'(DIV_ONE / 64'd7192);
    localparam logic [DIV_MW-1:0] RCP_UNIT_SEC    = DIV_MW'(DIV_ONE / 64'd120);

    function automatic logic [FIELD_W-1:0] fps_value(t_fps sel);
        case (sel)
            FPS_24:  fps_value = FIELD_W'(24);
            FPS_25:  fps_value = FIELD_W'(25);
            FPS_30:  fps_value = FIELD_W'(30);
            FPS_50:  fps_value = FIELD_W'(50);
            FPS_60:  fps_value = FIELD_W'(60);
            default: fps_value = FIELD_W'(24);
        endcase
    endfunction

    function automatic logic [DIV_MW-1:0] sec_rcp(t_fps sel);
        case (sel)
            FPS_24:  sec_rcp = DIV_MW'(DIV_ONE / 64'd24);
            FPS_25:  sec_rcp = DIV_MW'(DIV_ONE / 64'd25);
            FPS_30:  sec_rcp = DIV_MW'(DIV_ONE / 64'd30);
            FPS_50:  sec_rcp = DIV_MW'(DIV_ONE / 64'd50);
            FPS_60:  sec_rcp = DIV_MW'(DIV_ONE / 64'd60);
            default: sec_rcp = DIV_MW'(DIV_ONE / 64'd24);
        endcase
    endfunction

    function automatic logic [DIV_DW-1:0] min_div(t_fps sel);
        case (sel)
            FPS_24:  min_div = DIV_DW'(1440);
            FPS_25:  min_div = DIV_DW'(1500);
            FPS_30:  min_div = DIV_DW'(1800);
            FPS_50:  min_div = DIV_DW'(3000);
            FPS_60:  min_div = DIV_DW'(3600);
            default: min_div = DIV_DW'(1440);
        endcase
    endfunction

    function automatic logic [DIV_MW-1:0] min_rcp(t_fps sel);
        case (sel)
            FPS_24:  min_rcp = DIV_MW'(DIV_ONE / 64'd1440);
            FPS_25:  min_rcp = DIV_MW'(DIV_ONE / 64'd1500);
            FPS_30:  min_rcp = DIV_MW'(DIV_ONE / 64'd1800);
            FPS_50:  min_rcp = DIV_MW'(DIV_ONE / 64'd3000);
            FPS_60:  min_rcp = DIV_MW'(DIV_ONE / 64'd3600);
            default: min_rcp = DIV_MW'(DIV_ONE / 64'd1440);
        endcase
    endfunction

    function automatic logic [DIV_DW-1:0] hour_div(t_fps sel);
        case (sel)
            FPS_24:  hour_div = DIV_DW'(86400);
            FPS_25:  hour_div = DIV_DW'(90000);
            FPS_30:  hour_div = DIV_DW'(108000);
            FPS_50:  hour_div = DIV_DW'(180000);
            FPS_60:  hour_div = DIV_DW'(216000);
            default: hour_div = DIV_DW'(86400);
        endcase
    endfunction

    function automatic logic [DIV_MW-1:0] hour_rcp(t_fps sel);
        case (sel)
            FPS_24:  hour_rcp = DIV_MW'(DIV_ONE / 64'd86400);
            FPS_25:  hour_rcp = DIV_MW'(DIV_ONE / 64'd90000);
            FPS_30:  hour_rcp = DIV_MW'(DIV_ONE / 64'd108000);
            FPS_50:  hour_rcp = DIV_MW'(DIV_ONE / 64'd180000);
            FPS_60:  hour_rcp = DIV_MW'(DIV_ONE / 64'd216000);
            default: hour_rcp = DIV_MW'(DIV_ONE / 64'd86400);
        endcase
    endfunction

    // units per frame in drop-frame mode
    function automatic logic [2:0] drop_step(t_fps sel);
        case (sel)
            FPS_24:  drop_step = 3'd5;
            FPS_30:  drop_step = 3'd4;
            FPS_60:  drop_step = 3'd2;
            default: drop_step = 3'd4;
        endcase
    endfunction

    // r / k for r < 120, k in {2, 4, 5}
    function automatic logic [FIELD_W-1:0] step_div(logic [6:0] r, logic [2:0] k);
        logic [14:0] prod;
        prod = 15'(r) * 15'd205;
        case (k)
            3'd2:    step_div = FIELD_W'(r >> 1);
            3'd4:    step_div = FIELD_W'(r >> 2);
            3'd5:    step_div = FIELD_W'(prod >> 10);
            default: step_div = FIELD_W'(r >> 2);
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: design/ftc_div.sv
// Two-stage divide by a selected constant: reciprocal multiply, then one correction step.
// Depends on ftc_pkg for widths and the enable struct.
`timescale 1ns / 1ps
`default_nettype none

module ftc_div (
    input  logic                         i_clk,
    input  ftc_pkg::t_div_en             i_en,
    input  logic [ftc_pkg::DIV_XW-1:0]   i_x,
    input  logic [ftc_pkg::DIV_DW-1:0]   i_d,
    input  logic [ftc_pkg::DIV_MW-1:0]   i_m,
    output logic [ftc_pkg::DIV_MW-1:0]   o_q,
    output logic [ftc_pkg::DIV_DW-1:0]   o_r
);

    logic [ftc_pkg::DIV_XW-1:0] r_x;
    logic [ftc_pkg::DIV_DW-1:0] r_d;
    logic [ftc_pkg::DIV_PW-1:0] r_prod;
    logic [ftc_pkg::DIV_PW-1:0] n_prod;

    logic [ftc_pkg::DIV_MW-1:0] r_q;
    logic [ftc_pkg::DIV_DW-1:0] r_r;
    logic [ftc_pkg::DIV_MW-1:0] n_q;
    logic [ftc_pkg::DIV_DW-1:0] n_r;

    logic [ftc_pkg::DIV_MW-1:0]                 w_qest;
    logic [ftc_pkg::DIV_MW+ftc_pkg::DIV_DW-1:0] w_qd;
    logic [ftc_pkg::DIV_XW-1:0]                 w_rest;
    logic                                       w_fix;

    assign n_prod = ftc_pkg::DIV_PW'(i_x) * ftc_pkg::DIV_PW'(i_m);

    always_ff @(posedge i_clk) begin
        if (i_en.load_a) begin
            r_x    <= i_x;
            r_d    <= i_d;
            r_prod <= n_prod;
        end
    end

    // estimate is exact or one low
    always_comb begin
        w_qest = r_prod[ftc_pkg::DIV_PW-1 -: ftc_pkg::DIV_MW];
        w_qd   = (ftc_pkg::DIV_MW + ftc_pkg::DIV_DW)'(w_qest) *
                 (ftc_pkg::DIV_MW + ftc_pkg::DIV_DW)'(r_d);
        w_rest = r_x - w_qd[ftc_pkg::DIV_XW-1:0];
        w_fix  = (w_rest >= ftc_pkg::DIV_XW'(r_d));
        n_q    = w_fix ? w_qest + ftc_pkg::DIV_MW'(1) : w_qest;
        n_r    = w_fix ? ftc_pkg::DIV_DW'(w_rest - ftc_pkg::DIV_XW'(r_d))
                       : ftc_pkg::DIV_DW'(w_rest);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

`default_nettype wire

FILE: design/frame_to_timecode_unit.sv
// Top level: frame number to hours/minutes/seconds/frame timecode, ten-stage pipeline.
// Depends on ftc_pkg and four ftc_div instances.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one frame number per beat.
//   Output channel: o_out_valid / i_out_stall carry hours, minutes, seconds,
//   frame_in_second and top_of_minute, one result beat per input beat, in order.
//   APB port: drop_frame_enable at 0x0, rate_code at 0x4; write only while idle.
//   Throughput: one beat per cycle while the output is not stalled. Each input beat
//   passes through capture, the four two-stage constant dividers in series (hours,
//   ten-minute/minute, drop minute, second) and the output register before its
//   result beat leaves.
//   Each stage advances when it is empty or the one after it moves, so an
//   output stall fills the bubbles first; o_in_stall rises only when every
//   stage holds a beat. Nothing is lost or repeated under stall.
//   Reset: valid bits clear, drop_frame_enable = 0, rate_code = 4 (29.97).
//   Invalid rate codes give an all-zero result.
`timescale 1ns / 1ps
`default_nettype none

module frame_to_timecode_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [ftc_pkg::FRAME_NUMBER_WIDTH-1:0] i_frame_number,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ftc_pkg::HOURS_W-1:0]           o_hours,
    output logic [ftc_pkg::FIELD_W-1:0]           o_minutes,
    output logic [ftc_pkg::FIELD_W-1:0]           o_seconds,
    output logic [ftc_pkg::FIELD_W-1:0]           o_frame_in_second,
    output logic                                  o_top_of_minute
);

    localparam int STAGES = 10;

    typedef struct packed {
        logic                        drop;
        logic                        zero;
        ftc_pkg::t_fps               sel;
        logic [ftc_pkg::HOURS_W-1:0] hours;
        logic [ftc_pkg::FIELD_W-1:0] q2;
        logic [ftc_pkg::R2_W-1:0]    r2;
        logic                        low;
        logic [3:0]                  mdrop;
        logic                        top;
    } t_side;

    // config
    logic       r_dfe;
    logic [3:0] r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dfe  <= 1'b0;
            r_rate <= ftc_pkg::RC_2997;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ftc_pkg::REG_DFE:  r_dfe  <= pwdata[0];
                ftc_pkg::REG_RATE: r_rate <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ftc_pkg::REG_DFE:  prdata = {31'd0, r_dfe};
            ftc_pkg::REG_RATE: prdata = {28'd0, r_rate};
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // rate decode
    ftc_pkg::t_fps w_sel;
    logic          w_frac;
    logic          w_code_ok;
    logic          w_drop;

    always_comb begin
        w_sel     = ftc_pkg::FPS_24;
        w_frac    = 1'b0;
        w_code_ok = 1'b1;
        case (r_rate)
            ftc_pkg::RC_23976: begin
                w_sel  = ftc_pkg::FPS_24;
                w_frac = 1'b1;
            end
            ftc_pkg::RC_24: w_sel = ftc_pkg::FPS_24;
            ftc_pkg::RC_25: w_sel = ftc_pkg::FPS_25;
            ftc_pkg::RC_2997: begin
                w_sel  = ftc_pkg::FPS_30;
                w_frac = 1'b1;
            end
            ftc_pkg::RC_30: w_sel = ftc_pkg::FPS_30;
            ftc_pkg::RC_50: w_sel = ftc_pkg::FPS_50;
            ftc_pkg::RC_5994: begin
                w_sel  = ftc_pkg::FPS_60;
                w_frac = 1'b1;
            end
            ftc_pkg::RC_60: w_sel = ftc_pkg::FPS_60;
            default: w_code_ok = 1'b0;
        endcase
        w_drop = r_dfe && w_frac;
    end

    // pipeline control
    logic [STAGES-1:0] r_vld;
    logic [STAGES:0]   w_ready;

    always_comb begin
        w_ready[STAGES] = !i_out_stall;
        for (int i = STAGES - 1; i >= 0; i--) begin
            w_ready[i] = !r_vld[i] || w_ready[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ready[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (w_ready[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_ready[0];
    assign o_out_valid = r_vld[STAGES-1];

    // stage 0: capture, scale, pick hour divisor
    logic [ftc_pkg::DIV_XW-1:0] r_x1;
    logic [ftc_pkg::DIV_DW-1:0] r_d1;
    logic [ftc_pkg::DIV_MW-1:0] r_m1;
    logic [ftc_pkg::DIV_XW-1:0] n_x1;
    logic [ftc_pkg::DIV_DW-1:0] n_d1;
    logic [ftc_pkg::DIV_MW-1:0] n_m1;

    always_comb begin
        n_x1 = w_drop ? ftc_pkg::DIV_XW'(i_frame_number) *
                        ftc_pkg::DIV_XW'(ftc_pkg::drop_step(w_sel))
                      : ftc_pkg::DIV_XW'(i_frame_number);
        n_d1 = w_drop ? ftc_pkg::DIV_DROP_HOUR : ftc_pkg::hour_div(w_sel);
        n_m1 = w_drop ? ftc_pkg::RCP_DROP_HOUR : ftc_pkg::hour_rcp(w_sel);
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_x1 <= n_x1;
            r_d1 <= n_d1;
            r_m1 <= n_m1;
        end
    end

    // sideband per stage
    t_side r_side [0:STAGES-2];
    t_side n_side [0:STAGES-2];

    logic [ftc_pkg::DIV_MW-1:0] w_q1, w_q2, w_q3, w_q4;
    logic [ftc_pkg::DIV_DW-1:0] w_r1, w_r2, w_r3, w_r4;
    logic [ftc_pkg::DIV_XW-1:0] w_x2, w_x3, w_x4;
    logic [ftc_pkg::DIV_DW-1:0] w_d2, w_d4;
    logic [ftc_pkg::DIV_MW-1:0] w_m2, w_m4;
    logic                       w_low;
    logic [2:0]                 w_k6;

    always_comb begin
        n_side[0]      = '0;
        n_side[0].drop = w_drop;
        n_side[0].zero = !w_code_ok;
        n_side[0].sel  = w_sel;
        for (int i = 1; i < STAGES - 1; i++) begin
            n_side[i] = r_side[i-1];
        end
        n_side[3].hours = w_q1[ftc_pkg::HOURS_W-1:0];
        n_side[5].q2    = w_q2[ftc_pkg::FIELD_W-1:0];
        n_side[5].r2    = w_r2[ftc_pkg::R2_W-1:0];
        n_side[5].low   = w_low;
        if (r_side[6].drop && !r_side[6].low) begin
            n_side[7].mdrop = w_q3[3:0];
            n_side[7].top   = (w_q3 != '0) && (w_r3 < ftc_pkg::DIV_DW'(w_k6));
        end else begin
            n_side[7].mdrop = 4'd0;
            n_side[7].top   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STAGES - 1; i++) begin
            if (w_ready[i]) begin
                r_side[i] <= n_side[i];
            end
        end
    end

    // stages 1-2: hours
    ftc_div u_div_hour (
        .i_clk (i_clk),
        .i_en  (ftc_pkg::t_div_en'{load_a: w_ready[1], load_b: w_ready[2]}),
        .i_x   (r_x1),
        .i_d   (r_d1),
        .i_m   (r_m1),
        .o_q   (w_q1),
        .o_r   (w_r1)
    );

    // stages 3-4: ten-minute block (drop) or minute
    always_comb begin
        w_x2 = ftc_pkg::DIV_XW'(w_r1);
        w_d2 = r_side[2].drop ? ftc_pkg::DIV_DROP_TENMIN : ftc_pkg::min_div(r_side[2].sel);
        w_m2 = r_side[2].drop ? ftc_pkg::RCP_DROP_TENMIN : ftc_pkg::min_rcp(r_side[2].sel);
    end

    ftc_div u_div_min (
        .i_clk (i_clk),
        .i_en  (ftc_pkg::t_div_en'{load_a: w_ready[3], load_b: w_ready[4]}),
        .i_x   (w_x2),
        .i_d   (w_d2),
        .i_m   (w_m2),
        .o_q   (w_q2),
        .o_r   (w_r2)
    );

    // stages 5-6: minute inside a ten-minute block, after the dropped units
    always_comb begin
        w_low = (w_r2 < ftc_pkg::DROP_UNITS);
        w_x3  = w_low ? '0 : ftc_pkg::DIV_XW'(w_r2 - ftc_pkg::DROP_UNITS);
    end

    ftc_div u_div_drop (
        .i_clk (i_clk),
        .i_en  (ftc_pkg::t_div_en'{load_a: w_ready[5], load_b: w_ready[6]}),
        .i_x   (w_x3),
        .i_d   (ftc_pkg::DIV_DROP_MIN),
        .i_m   (ftc_pkg::RCP_DROP_MIN),
        .o_q   (w_q3),
        .o_r   (w_r3)
    );

    // stages 7-8: seconds
    always_comb begin
        w_k6 = ftc_pkg::drop_step(r_side[6].sel);
        if (r_side[6].drop && !r_side[6].low) begin
            w_x4 = ftc_pkg::DIV_XW'(w_r3 + ftc_pkg::DROP_UNITS);
        end else begin
            w_x4 = ftc_pkg::DIV_XW'(r_side[6].r2);
        end
        w_d4 = r_side[6].drop ? ftc_pkg::DIV_UNIT_SEC
                              : ftc_pkg::DIV_DW'(ftc_pkg::fps_value(r_side[6].sel));
        w_m4 = r_side[6].drop ? ftc_pkg::RCP_UNIT_SEC : ftc_pkg::sec_rcp(r_side[6].sel);
    end

    ftc_div u_div_sec (
        .i_clk (i_clk),
        .i_en  (ftc_pkg::t_div_en'{load_a: w_ready[7], load_b: w_ready[8]}),
        .i_x   (w_x4),
        .i_d   (w_d4),
        .i_m   (w_m4),
        .o_q   (w_q4),
        .o_r   (w_r4)
    );

    // stage 9: output register
    logic [ftc_pkg::HOURS_W-1:0] r_hours, n_hours;
    logic [ftc_pkg::FIELD_W-1:0] r_minutes, n_minutes;
    logic [ftc_pkg::FIELD_W-1:0] r_seconds, n_seconds;
    logic [ftc_pkg::FIELD_W-1:0] r_frame, n_frame;
    logic                        r_top, n_top;

    always_comb begin
        n_hours   = r_side[8].hours;
        n_seconds = w_q4[ftc_pkg::FIELD_W-1:0];
        n_top     = r_side[8].top;
        if (r_side[8].drop) begin
            n_minutes = ftc_pkg::FIELD_W'(r_side[8].q2 * ftc_pkg::FIELD_W'(10)) +
                        ftc_pkg::FIELD_W'(r_side[8].mdrop);
            n_frame   = ftc_pkg::step_div(w_r4[6:0], ftc_pkg::drop_step(r_side[8].sel));
        end else begin
            n_minutes = r_side[8].q2;
            n_frame   = w_r4[ftc_pkg::FIELD_W-1:0];
        end
        if (r_side[8].zero) begin
            n_hours   = '0;
            n_minutes = '0;
            n_seconds = '0;
            n_frame   = '0;
            n_top     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[STAGES-1]) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
            r_frame   <= n_frame;
            r_top     <= n_top;
        end
    end

    assign o_hours           = r_hours;
    assign o_minutes         = r_minutes;
    assign o_seconds         = r_seconds;
    assign o_frame_in_second = r_frame;
    assign o_top_of_minute   = r_top;

endmodule

`default_nettype wire

FILE: design/ftc_checker.sv
// Port-level assertions for frame_to_timecode_unit, attached by bind.
// Depends on ftc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module ftc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [ftc_pkg::HOURS_W-1:0] o_hours,
    input wire logic [ftc_pkg::FIELD_W-1:0] o_minutes,
    input wire logic [ftc_pkg::FIELD_W-1:0] o_seconds,
    input wire logic [ftc_pkg::FIELD_W-1:0] o_frame_in_second,
    input wire logic                        o_top_of_minute
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || !i_out_stall) |-> !o_in_stall)
        else $error("input stalled while output side can move");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_hours) && $stable(o_minutes) &&
             $stable(o_seconds) && $stable(o_frame_in_second) &&
             $stable(o_top_of_minute)))
        else $error("stalled output beat changed");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_minutes <= 6'd59 && o_seconds <= 6'd59 &&
                         o_frame_in_second <= 6'd59))
        else $error("timecode field out of range");

    a_top_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_top_of_minute) |->
            (o_seconds == 6'd0 && o_minutes != 6'd0 &&
             o_frame_in_second != 6'd0 && o_frame_in_second <= 6'd4))
        else $error("top of minute on a non-dropped position");

endmodule

bind frame_to_timecode_unit ftc_checker u_ftc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_hours           (o_hours),
    .o_minutes         (o_minutes),
    .o_seconds         (o_seconds),
    .o_frame_in_second (o_frame_in_second),
    .o_top_of_minute   (o_top_of_minute)
);

`default_nettype wire

FILE: tb/sv/tb_frame_to_timecode_unit.sv
// Self-checking testbench for frame_to_timecode_unit: a directed table, then random frames
// under rate and drop-frame settings with idle and stall phases, checked by an in-bench model.
// Depends on ftc_pkg and frame_to_timecode_unit.
`timescale 1ns / 1ps

module tb_frame_to_timecode_unit;
    import ftc_pkg::*;

    localparam int LATENCY        = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int SEGMENTS       = 12;
    localparam int SEG_ITEMS      = 50;

    localparam longint UNITS_SEC      = 120;
    localparam longint UNITS_TEN_MIN  = (10 * 60 * 30 - 18) * 4;
    localparam longint UNITS_DROP_MIN = (60 * 30 - 2) * 4;
    localparam longint UNITS_SKIP     = 2 * 4;

    localparam logic [3:0] RC_BAD_0  = 4'd0;
    localparam logic [3:0] RC_BAD_9  = 4'd9;
    localparam logic [3:0] RC_BAD_15 = 4'd15;

    localparam logic [FRAME_NUMBER_WIDTH-1:0] FRAME_MAX = '1;

    typedef struct packed {
        logic [HOURS_W-1:0] hours;
        logic [FIELD_W-1:0] minutes;
        logic [FIELD_W-1:0] seconds;
        logic [FIELD_W-1:0] frame_in_second;
        logic               top_of_minute;
    } t_timecode;

    typedef struct {
        logic                          dfe;
        logic [3:0]                    rate;
        logic [FRAME_NUMBER_WIDTH-1:0] frame;
        bit                            typed;
        t_timecode                     result;
    } t_case;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [FRAME_NUMBER_WIDTH-1:0] i_frame_number;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [HOURS_W-1:0]            o_hours;
    logic [FIELD_W-1:0]            o_minutes;
    logic [FIELD_W-1:0]            o_seconds;
    logic [FIELD_W-1:0]            o_frame_in_second;
    logic                          o_top_of_minute;

    t_timecode   timecode_q[$];
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    bit          hold_req = 1'b0;
    logic        cfg_dfe = 1'b0;
    logic [3:0]  cfg_rate = RC_2997;

    frame_to_timecode_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_frame_number    (i_frame_number),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_hours           (o_hours),
        .o_minutes         (o_minutes),
        .o_seconds         (o_seconds),
        .o_frame_in_second (o_frame_in_second),
        .o_top_of_minute   (o_top_of_minute)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_timecode tc(int h, int m, int s, int f, bit top);
        t_timecode r;
        r.hours           = HOURS_W'(h);
        r.minutes         = FIELD_W'(m);
        r.seconds         = FIELD_W'(s);
        r.frame_in_second = FIELD_W'(f);
        r.top_of_minute   = top;
        return r;
    endfunction

    function automatic t_timecode calc_timecode(logic dfe, logic [3:0] rate,
                                                logic [FRAME_NUMBER_WIDTH-1:0] frame);
        longint fps, k, f, h, m, s, fr;
        logic   top;
        fps = 0;
        k   = 1;
        top = 1'b0;
        case (rate)
            RC_23976, RC_24: fps = 24;
            RC_25:           fps = 25;
            RC_2997, RC_30:  fps = 30;
            RC_50:           fps = 50;
            RC_5994, RC_60:  fps = 60;
            default:         fps = 0;
        endcase
        f = longint'(frame);
        if (fps == 0) begin
            h = 0; m = 0; s = 0; fr = 0;
        end else if (dfe && (rate == RC_23976 || rate == RC_2997 || rate == RC_5994)) begin
            k = UNITS_SEC / fps;
            f = f * k;
            h = f / UNITS_TEN_MIN;
            f = f % UNITS_TEN_MIN;
            f = f - UNITS_SKIP;
            m = f / UNITS_DROP_MIN;
            top = ((f - k) / UNITS_DROP_MIN) < m;
            m = m + (h % 6) * 10;
            h = h / 6;
            f = f % UNITS_DROP_MIN;
            f = f + UNITS_SKIP;
            s = f / UNITS_SEC;
            f = f % UNITS_SEC;
            fr = f / k;
        end else begin
            s  = f / fps;
            fr = f % fps;
            m  = s / 60;
            s  = s % 60;
            h  = m / 60;
            m  = m % 60;
        end
        return tc(int'(h[HOURS_W-1:0]), int'(m[FIELD_W-1:0]), int'(s[FIELD_W-1:0]),
                  int'(fr[FIELD_W-1:0]), top);
    endfunction

    // frames clustered around dropped-minute starts, plus wide, low and high values
    function automatic logic [FRAME_NUMBER_WIDTH-1:0] pick_frame(logic [3:0] rate);
        int unsigned sel;
        longint      k, units;
        sel = $urandom_range(0, 99);
        case (rate)
            RC_23976:               k = 5;
            RC_50, RC_5994, RC_60:  k = 2;
            default:                k = 4;
        endcase
        if (sel < 40) begin
            units = longint'($urandom_range(0, 7400)) * UNITS_TEN_MIN
                  + longint'($urandom_range(0, 9)) * UNITS_DROP_MIN + UNITS_SKIP
                  + longint'($urandom_range(0, 12)) - 6;
            return FRAME_NUMBER_WIDTH'(units / k);
        end else if (sel < 70) begin
            return FRAME_NUMBER_WIDTH'($urandom);
        end else if (sel < 85) begin
            return FRAME_NUMBER_WIDTH'($urandom_range(0, 4000));
        end else begin
            return FRAME_MAX - FRAME_NUMBER_WIDTH'($urandom_range(0, 4000));
        end
    endfunction

    function automatic void report_mismatch(string what, t_timecode want, t_timecode got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("tb: %s exp h=%0d m=%0d s=%0d f=%0d top=%0d got h=%0d m=%0d s=%0d f=%0d top=%0d",
                     what, want.hours, want.minutes, want.seconds, want.frame_in_second,
                     want.top_of_minute, got.hours, got.minutes, got.seconds,
                     got.frame_in_second, got.top_of_minute);
        end
    endfunction

    task automatic apb_write(logic reg_sel, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (timecode_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic apply_config(logic dfe, logic [3:0] rate);
        wait_drained();
        apb_write(REG_DFE, 32'(dfe));
        apb_write(REG_RATE, 32'(rate));
        cfg_dfe  = dfe;
        cfg_rate = rate;
    endtask

    task automatic send_frame(logic [FRAME_NUMBER_WIDTH-1:0] frame, bit typed,
                              t_timecode typed_result);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_frame_number <= frame;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        timecode_q.push_back(typed ? typed_result : calc_timecode(cfg_dfe, cfg_rate, frame));
    endtask

    initial begin : receiver
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_timecode want;
        t_timecode got;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = '{o_hours, o_minutes, o_seconds, o_frame_in_second, o_top_of_minute};
            if (timecode_q.size() == 0) begin
                report_mismatch("unexpected beat", '0, got);
            end else begin
                want = timecode_q.pop_front();
                if (got.hours !== want.hours || got.minutes !== want.minutes ||
                    got.seconds !== want.seconds ||
                    got.frame_in_second !== want.frame_in_second ||
                    got.top_of_minute !== want.top_of_minute)
                    report_mismatch("mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        t_case      stim_table[$];
        logic       dfe;
        logic [3:0] rate;
        int unsigned mode;

        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        i_in_valid     = 1'b0;
        i_frame_number = '0;

        stim_table = '{
            '{1'b0, RC_2997,   28'd0,      1'b1, tc(0, 0, 0, 0, 0)},
            '{1'b0, RC_2997,   28'd30,     1'b1, tc(0, 0, 1, 0, 0)},
            '{1'b0, RC_2997,   FRAME_MAX,  1'b0, '0},
            '{1'b0, RC_60,     FRAME_MAX,  1'b1, tc(1242, 45, 24, 15, 0)},
            '{1'b1, RC_60,     28'd3600,   1'b1, tc(0, 1, 0, 0, 0)},
            '{1'b1, RC_2997,   28'd1800,   1'b1, tc(0, 1, 0, 2, 1)},
            '{1'b1, RC_2997,   28'd1799,   1'b0, '0},
            '{1'b1, RC_2997,   28'd1801,   1'b0, '0},
            '{1'b1, RC_2997,   28'd17982,  1'b0, '0},
            '{1'b1, RC_2997,   FRAME_MAX,  1'b0, '0},
            '{1'b1, RC_23976,  28'd1440,   1'b1, tc(0, 1, 0, 1, 1)},
            '{1'b1, RC_23976,  28'd0,      1'b1, tc(0, 0, 0, 0, 0)},
            '{1'b1, RC_23976,  FRAME_MAX,  1'b0, '0},
            '{1'b1, RC_5994,   28'd3600,   1'b1, tc(0, 1, 0, 4, 1)},
            '{1'b1, RC_5994,   FRAME_MAX,  1'b0, '0},
            '{1'b1, RC_24,     28'd86400,  1'b1, tc(1, 0, 0, 0, 0)},
            '{1'b1, RC_25,     FRAME_MAX,  1'b0, '0},
            '{1'b0, RC_30,     28'd107999, 1'b0, '0},
            '{1'b0, RC_50,     28'd12345678, 1'b0, '0},
            '{1'b0, RC_23976,  28'd1440,   1'b0, '0},
            '{1'b0, RC_BAD_0,  FRAME_MAX,  1'b1, tc(0, 0, 0, 0, 0)},
            '{1'b0, RC_BAD_15, 28'd12345,  1'b1, tc(0, 0, 0, 0, 0)},
            '{1'b1, RC_BAD_9,  28'd1800,   1'b1, tc(0, 0, 0, 0, 0)},
            '{1'b0, RC_5994,   28'd0,      1'b1, tc(0, 0, 0, 0, 0)}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].dfe !== cfg_dfe || stim_table[i].rate !== cfg_rate)
                apply_config(stim_table[i].dfe, stim_table[i].rate);
            send_frame(stim_table[i].frame, stim_table[i].typed, stim_table[i].result);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            dfe = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 85)
                rate = 4'($urandom_range(RC_23976, RC_60));
            else
                rate = 4'($urandom_range(9, 16));   // 16 wraps to code 0
            apply_config(dfe, rate);
            mode = seg % 4;
            idle_pct  = (mode == 1) ? 49 : (mode == 3) ? 10 : 0;
            stall_pct = (mode == 2) ? 49 : (mode == 3) ? 10 : 0;
            if (seg == 0 || seg == 8)
                hold_req = 1'b1;
            for (int n = 0; n < SEG_ITEMS; n++)
                send_frame(pick_frame(rate), 1'b0, '0);
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && timecode_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
